FILE: src/gsr_pkg.sv
// Shared types and codes for the gamepad serial responder.
// No dependencies; imported by gamepad_serial_responder.
`default_nettype none

package gsr_pkg;

    // Width of a payload position and of a report index field
    localparam int unsigned POS_W = 5;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_HOST  = 2'd0,
        OP_ABORT = 2'd1,
        OP_LOAD  = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    // Frame phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_CMD  = 2'd1,
        PH_PAY  = 2'd2
    } t_phase;

    // Pad mode
    typedef enum logic [1:0] {
        MODE_DIG = 2'd0,
        MODE_ANA = 2'd1,
        MODE_PRS = 2'd2
    } t_mode;

    // Host command codes
    localparam logic [7:0] CMD_PRES_INIT = 8'h40;
    localparam logic [7:0] CMD_BTN_MASK  = 8'h41;
    localparam logic [7:0] CMD_READ_PAD  = 8'h42;
    localparam logic [7:0] CMD_CFG_MODE  = 8'h43;
    localparam logic [7:0] CMD_SET_MODE  = 8'h44;
    localparam logic [7:0] CMD_PAD_INFO  = 8'h45;
    localparam logic [7:0] CMD_ACT_INFO  = 8'h46;
    localparam logic [7:0] CMD_COMB_INFO = 8'h47;
    localparam logic [7:0] CMD_MODE_INFO = 8'h4C;
    localparam logic [7:0] CMD_MOTOR     = 8'h4D;
    localparam logic [7:0] CMD_PRES_CFG  = 8'h4F;

    // Frame bytes and mode IDs
    localparam logic [7:0] FRAME_START = 8'h01;
    localparam logic [7:0] ACK_BYTE    = 8'h5A;
    localparam logic [7:0] ID_DIG      = 8'h41;
    localparam logic [7:0] ID_ANA      = 8'h73;
    localparam logic [7:0] ID_PRS      = 8'h79;
    localparam logic [7:0] ID_CFG      = 8'hF3;

    // Input beat
    typedef struct packed {
        t_opcode          opcode;
        logic [7:0]       host_byte;
        logic [POS_W-1:0] report_index;
        logic [7:0]       report_value;
    } t_in_item;

    // Output beat
    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       frame_done;
    } t_out_item;

endpackage

`default_nettype wire

FILE: src/gamepad_serial_responder.sv
// Channel  | dir | handshake              | payload
// in       | in  | i_in_valid/o_in_stall  | i_in_data  (t_in_item)
// out      | out | o_out_valid/i_out_stall| o_out_data (t_out_item)
//
// One item per cycle while o_in_stall is low; each accepted item yields one result beat.
// The frame state and stores update in the accept cycle; the result lands in an
// output register, with one skid register behind it when the output is stalled.
// o_in_stall rises only while the skid register is full.
// Synchronous active-low reset clears the frame state, report and setup, and sets the motor map to 8'hFF.
// Top level of the gamepad serial responder; depends on gsr_pkg.
`default_nettype none

module gamepad_serial_responder
    import gsr_pkg::*;
#(
    parameter int unsigned REPORT_BYTES = 19,
    parameter int unsigned MOTOR_SLOTS  = 6
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);

    localparam int unsigned IDX_W  = (REPORT_BYTES > 1) ? $clog2(REPORT_BYTES) : 1;
    localparam int unsigned MIDX_W = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;
    localparam logic [POS_W:0]   RPT_LEN = (POS_W + 1)'(REPORT_BYTES);
    localparam logic [POS_W-1:0] MOT_LEN = POS_W'(MOTOR_SLOTS);

    // State
    logic [7:0]                   r_report [REPORT_BYTES];
    t_mode                        r_mode;
    logic                         r_config;
    logic [MOTOR_SLOTS-1:0][7:0]  r_motor;
    logic [3:0][7:0]              r_press;
    t_phase                       r_phase;
    logic [7:0]                   r_cmd;
    logic [POS_W-1:0]             r_pos;
    logic [7:0]                   r_page;

    // Values after decode / absorb of the current beat
    t_mode                        a_mode;
    logic                         a_config;
    logic [MOTOR_SLOTS-1:0][7:0]  a_motor;
    logic [3:0][7:0]              a_press;
    logic [7:0]                   a_cmd;
    logic [7:0]                   a_page;

    t_phase                       n_phase;
    logic [POS_W-1:0]             n_pos;
    t_mode                        n_mode;

    // Output register and skid
    logic       r_out_valid;
    t_out_item  r_out;
    logic       r_skid_valid;
    t_out_item  r_skid;
    t_out_item  n_res;

    logic             acc;
    logic             pop;
    logic             is_host;
    logic [7:0]       h;
    logic             cmd_ok;
    logic             shows;
    logic [POS_W:0]   frame_len;
    logic [POS_W:0]   pos_inc;
    logic             frame_end;
    logic [POS_W-1:0] q;
    logic [POS_W-1:0] m;
    logic             dig;
    logic             off0;
    logic [7:0]       pay_byte;
    logic [7:0]       mode_id;

    assign acc     = i_in_valid && !r_skid_valid;
    assign pop     = r_out_valid && !i_out_stall;
    assign h       = i_in_data.host_byte;
    assign is_host = acc && (i_in_data.opcode == OP_HOST);
    assign cmd_ok  = (h == CMD_READ_PAD) || (h == CMD_CFG_MODE) ||
                     (r_config && (h inside {CMD_PRES_INIT, CMD_BTN_MASK, CMD_SET_MODE,
                                            CMD_PAD_INFO, CMD_ACT_INFO, CMD_COMB_INFO,
                                            CMD_MODE_INFO, CMD_MOTOR, CMD_PRES_CFG}));

    // Command decode and payload absorb
    always_comb begin
        a_mode   = r_mode;
        a_config = r_config;
        a_motor  = r_motor;
        a_press  = r_press;
        a_cmd    = r_cmd;
        a_page   = r_page;
        if (is_host && r_phase == PH_CMD) begin
            a_cmd = h;
            if (cmd_ok) begin
                if (h == CMD_READ_PAD) begin
                    a_config = 1'b0;
                end
                a_page = (h == CMD_CFG_MODE) ? {7'd0, r_config} : 8'd0;
            end
        end else if (is_host && r_phase == PH_PAY) begin
            case (r_cmd)
                CMD_CFG_MODE: begin
                    if (r_pos == POS_W'(1)) a_config = (h != 8'd0);
                end
                CMD_SET_MODE: begin
                    if (r_pos == POS_W'(1)) begin
                        if (h == FRAME_START) a_mode = (|r_press) ? MODE_PRS : MODE_ANA;
                        else a_mode = MODE_DIG;
                    end
                end
                CMD_ACT_INFO, CMD_MODE_INFO: begin
                    if (r_pos == POS_W'(1)) a_page = h;
                end
                CMD_MOTOR: begin
                    for (int k = 0; k < MOTOR_SLOTS; k++) begin
                        if (k < 6 && r_pos == POS_W'(k + 1)) a_motor[k] = h;
                    end
                end
                CMD_PRES_CFG: begin
                    for (int k = 0; k < 4; k++) begin
                        if (r_pos == POS_W'(k + 1)) a_press[k] = h;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Frame length and end-of-frame test
    always_comb begin
        shows = (a_cmd == CMD_READ_PAD) || (a_cmd == CMD_CFG_MODE && a_page == 8'd0);
        if (!shows) frame_len = (POS_W + 1)'(7);
        else if (a_mode == MODE_ANA) frame_len = (POS_W + 1)'(7);
        else if (a_mode == MODE_PRS) frame_len = RPT_LEN;
        else frame_len = (POS_W + 1)'(3);
    end

    assign pos_inc   = {1'b0, r_pos} + (POS_W + 1)'(1);
    assign frame_end = (pos_inc >= frame_len);

    // Byte for the next slot at position q
    assign q    = (r_phase == PH_CMD) ? '0 : pos_inc[POS_W-1:0];
    assign m    = q - POS_W'(1);
    assign dig  = (a_mode == MODE_DIG);
    assign off0 = (a_page == 8'd0);

    always_comb begin
        pay_byte = 8'd0;
        if (shows) begin
            if ({1'b0, q} < RPT_LEN) pay_byte = r_report[q[IDX_W-1:0]];
        end else if (q == '0) begin
            pay_byte = ACK_BYTE;
        end else begin
            case (a_cmd)
                CMD_PRES_INIT: begin
                    if (q == POS_W'(3)) pay_byte = 8'h02;
                    else if (q == POS_W'(6)) pay_byte = ACK_BYTE;
                end
                CMD_BTN_MASK: begin
                    if (!dig) begin
                        if (q == POS_W'(1) || q == POS_W'(2)) pay_byte = 8'hFF;
                        else if (q == POS_W'(3)) pay_byte = 8'h03;
                        else if (q == POS_W'(6)) pay_byte = ACK_BYTE;
                    end
                end
                CMD_PAD_INFO: begin
                    if (q == POS_W'(1)) pay_byte = 8'h01;
                    else if (q == POS_W'(2)) pay_byte = 8'h02;
                    else if (q == POS_W'(3)) pay_byte = dig ? 8'h00 : 8'h01;
                    else if (q == POS_W'(4)) pay_byte = 8'h02;
                    else if (q == POS_W'(5)) pay_byte = 8'h01;
                end
                CMD_ACT_INFO: begin
                    if (q == POS_W'(3)) pay_byte = 8'h01;
                    else if (q == POS_W'(4)) pay_byte = off0 ? 8'h02 : 8'h01;
                    else if (q == POS_W'(5)) pay_byte = off0 ? 8'h00 : 8'h01;
                    else if (q == POS_W'(6)) pay_byte = 8'h0F;
                end
                CMD_COMB_INFO: begin
                    if (q == POS_W'(3)) pay_byte = 8'h02;
                    else if (q == POS_W'(5)) pay_byte = 8'h01;
                end
                CMD_MODE_INFO: begin
                    if (q == POS_W'(4)) pay_byte = off0 ? 8'h04 : 8'h07;
                end
                CMD_MOTOR: begin
                    if (m < MOT_LEN) pay_byte = a_motor[m[MIDX_W-1:0]];
                    else pay_byte = 8'hFF;
                end
                CMD_PRES_CFG: begin
                    if (q == POS_W'(6)) pay_byte = ACK_BYTE;
                end
                default: begin
                end
            endcase
        end
    end

    // Mode ID for the first reply byte
    always_comb begin
        if (r_config) mode_id = ID_CFG;
        else if (r_mode == MODE_ANA) mode_id = ID_ANA;
        else if (r_mode == MODE_PRS) mode_id = ID_PRS;
        else mode_id = ID_DIG;
    end

    // Next frame state
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_mode  = a_mode;
        if (acc) begin
            case (i_in_data.opcode)
                OP_ABORT: begin
                    n_phase = PH_IDLE;
                    n_pos   = '0;
                end
                OP_HOST: begin
                    case (r_phase)
                        PH_CMD: begin
                            if (cmd_ok) begin
                                n_phase = PH_PAY;
                                n_pos   = '0;
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end
                        PH_PAY: begin
                            if (frame_end) begin
                                if (a_cmd == CMD_PRES_CFG) begin
                                    n_mode = (|a_press) ? MODE_PRS : MODE_ANA;
                                end
                                n_phase = PH_IDLE;
                                n_pos   = '0;
                            end else begin
                                n_pos = pos_inc[POS_W-1:0];
                            end
                        end
                        default: begin
                            n_phase = (h == FRAME_START) ? PH_CMD : PH_IDLE;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // Result beat
    always_comb begin
        n_res = '0;
        if (is_host) begin
            case (r_phase)
                PH_CMD: begin
                    if (cmd_ok) begin
                        n_res.tx_valid = 1'b1;
                        n_res.tx_byte  = pay_byte;
                    end else begin
                        n_res.frame_done = 1'b1;
                    end
                end
                PH_PAY: begin
                    if (frame_end) begin
                        n_res.frame_done = 1'b1;
                    end else begin
                        n_res.tx_valid = 1'b1;
                        n_res.tx_byte  = pay_byte;
                    end
                end
                default: begin
                    if (h == FRAME_START) begin
                        n_res.tx_valid = 1'b1;
                        n_res.tx_byte  = mode_id;
                    end
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < REPORT_BYTES; k++) r_report[k] <= 8'd0;
            r_mode   <= MODE_DIG;
            r_config <= 1'b0;
            r_motor  <= '1;
            r_press  <= '0;
            r_phase  <= PH_IDLE;
            r_cmd    <= 8'd0;
            r_pos    <= '0;
            r_page   <= 8'd0;
        end else begin
            r_mode   <= n_mode;
            r_config <= a_config;
            r_motor  <= a_motor;
            r_press  <= a_press;
            r_phase  <= n_phase;
            r_cmd    <= a_cmd;
            r_pos    <= n_pos;
            r_page   <= a_page;
            // report load, bytes 1 and 2 held inverted
            if (acc && i_in_data.opcode == OP_LOAD &&
                {1'b0, i_in_data.report_index} < RPT_LEN) begin
                if (i_in_data.report_index == POS_W'(1) ||
                    i_in_data.report_index == POS_W'(2)) begin
                    r_report[i_in_data.report_index[IDX_W-1:0]] <= ~i_in_data.report_value;
                end else begin
                    r_report[i_in_data.report_index[IDX_W-1:0]] <= i_in_data.report_value;
                end
            end
        end
    end

    // Output register and skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= acc;
            end
        end else if (acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (acc) begin
            r_skid <= n_res;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // skid holds a beat only behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid full with output register empty");

    // output valid is always high in the cycle after a beat is accepted
    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted beat lost");

    // a beat never both drives a byte and ends the frame
    a_done_no_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.tx_valid && o_out_data.frame_done))
        else $error("tx and frame end in one beat");

    // undriven slot carries zero
    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.tx_valid) |-> (o_out_data.tx_byte == 8'd0))
        else $error("nonzero byte without tx_valid");

    // payload position is parked at zero outside the payload phase
    a_pos_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_PAY) |-> (r_pos == '0))
        else $error("position nonzero outside payload");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_gamepad_serial_responder.sv
// Self-checking testbench for gamepad_serial_responder: a directed table, then random frames.
// Behavioral pad model predicts replies the table leaves open; needs gsr_pkg and the RTL.
module tb_gamepad_serial_responder
    import gsr_pkg::*;
();

    localparam int NREPORT    = 19;
    localparam int NMOTOR     = 6;
    localparam int RAND_BEATS = 1750;

    typedef struct {
        t_in_item  beat;
        bit        fixed;
        t_out_item want;
    } t_dir_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    t_in_item  i_in_data = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    // pad model state
    logic [7:0] rpt [NREPORT];
    logic [7:0] motor [NMOTOR];
    logic [7:0] pres_cfg [4];
    t_mode      pad_mode;
    logic       cfg_on;
    t_phase     pad_phase;
    logic [7:0] pad_cmd;
    logic [4:0] pad_pos;
    logic [7:0] page;

    t_out_item   pending_replies[$];
    t_dir_row    dir_rows[$];
    int          n_err = 0;
    int          n_checked = 0;
    int          n_frames = 0;
    int          n_sent = 0;
    bit          in_calm = 1'b0;
    bit          out_calm = 1'b0;
    int unsigned hold_left = 0;

    gamepad_serial_responder #(
        .REPORT_BYTES(NREPORT),
        .MOTOR_SLOTS (NMOTOR)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit pres_nonzero();
        return (pres_cfg[0] | pres_cfg[1] | pres_cfg[2] | pres_cfg[3]) != 8'h00;
    endfunction

    // poll, and config opened outside config mode, return the report itself
    function automatic bit report_cmd();
        return pad_cmd == CMD_READ_PAD || (pad_cmd == CMD_CFG_MODE && page == 8'h00);
    endfunction

    // byte the pad drives at payload position p
    function automatic logic [7:0] slot_byte(int p);
        logic dig;
        logic off0;
        dig  = (pad_mode == MODE_DIG);
        off0 = (page == 8'h00);
        if (report_cmd()) return (p < NREPORT) ? rpt[p] : 8'h00;
        if (p == 0) return ACK_BYTE;
        case (pad_cmd)
            CMD_PRES_INIT: return (p == 3) ? 8'h02 : (p == 6) ? ACK_BYTE : 8'h00;
            CMD_BTN_MASK: begin
                if (dig) return 8'h00;
                return (p == 1 || p == 2) ? 8'hFF : (p == 3) ? 8'h03 :
                       (p == 6) ? ACK_BYTE : 8'h00;
            end
            CMD_PAD_INFO: begin
                case (p)
                    1: return 8'h01;
                    2: return 8'h02;
                    3: return dig ? 8'h00 : 8'h01;
                    4: return 8'h02;
                    5: return 8'h01;
                    default: return 8'h00;
                endcase
            end
            CMD_ACT_INFO: begin
                case (p)
                    3: return 8'h01;
                    4: return off0 ? 8'h02 : 8'h01;
                    5: return off0 ? 8'h00 : 8'h01;
                    6: return 8'h0F;
                    default: return 8'h00;
                endcase
            end
            CMD_COMB_INFO: return (p == 3) ? 8'h02 : (p == 5) ? 8'h01 : 8'h00;
            CMD_MODE_INFO: return (p == 4) ? (off0 ? 8'h04 : 8'h07) : 8'h00;
            CMD_MOTOR:     return (p <= NMOTOR) ? motor[p-1] : 8'hFF;
            CMD_PRES_CFG:  return (p == 6) ? ACK_BYTE : 8'h00;
            default:       return 8'h00;
        endcase
    endfunction

    // advance the pad model by one input beat and return the reply beat
    function automatic t_out_item answer_host(t_in_item it);
        t_out_item  r;
        logic [7:0] h;
        int         p;
        int         flen;
        r = '0;
        h = it.host_byte;
        case (it.opcode)
            OP_ABORT: begin
                pad_phase = PH_IDLE;
                pad_pos   = '0;
            end
            OP_LOAD: begin
                if (it.report_index < NREPORT)
                    rpt[it.report_index] = (it.report_index == 1 || it.report_index == 2) ?
                                           ~it.report_value : it.report_value;
            end
            OP_HOST: begin
                if (pad_phase == PH_CMD) begin
                    pad_cmd = h;
                    if (!(h == CMD_READ_PAD || h == CMD_CFG_MODE ||
                          (cfg_on && h inside {CMD_PRES_INIT, CMD_BTN_MASK, CMD_SET_MODE,
                                               CMD_PAD_INFO, CMD_ACT_INFO, CMD_COMB_INFO,
                                               CMD_MODE_INFO, CMD_MOTOR,
                                               CMD_PRES_CFG}))) begin
                        // refused command closes the frame at once
                        pad_phase    = PH_IDLE;
                        r.frame_done = 1'b1;
                    end else begin
                        if (h == CMD_READ_PAD) cfg_on = 1'b0;
                        page       = (h == CMD_CFG_MODE) ? {7'd0, cfg_on} : 8'h00;
                        pad_pos    = '0;
                        pad_phase  = PH_PAY;
                        r.tx_valid = 1'b1;
                        r.tx_byte  = slot_byte(0);
                    end
                end else if (pad_phase == PH_PAY) begin
                    p = pad_pos;
                    // host byte side effects
                    case (pad_cmd)
                        CMD_CFG_MODE: if (p == 1) cfg_on = (h != 8'h00);
                        CMD_SET_MODE: begin
                            if (p == 1)
                                pad_mode = (h == 8'h01) ?
                                           (pres_nonzero() ? MODE_PRS : MODE_ANA) : MODE_DIG;
                        end
                        CMD_ACT_INFO, CMD_MODE_INFO: if (p == 1) page = h;
                        CMD_MOTOR: if (p >= 1 && p <= NMOTOR && p <= 6) motor[p-1] = h;
                        CMD_PRES_CFG: if (p >= 1 && p <= 4) pres_cfg[p-1] = h;
                        default: ;
                    endcase
                    if (report_cmd())
                        flen = (pad_mode == MODE_ANA) ? 7 : (pad_mode == MODE_PRS) ? NREPORT : 3;
                    else
                        flen = 7;
                    if (p + 1 >= flen) begin
                        if (pad_cmd == CMD_PRES_CFG)
                            pad_mode = pres_nonzero() ? MODE_PRS : MODE_ANA;
                        pad_phase    = PH_IDLE;
                        pad_pos      = '0;
                        r.frame_done = 1'b1;
                    end else begin
                        pad_pos    = 5'(p + 1);
                        r.tx_valid = 1'b1;
                        r.tx_byte  = slot_byte(p + 1);
                    end
                end else if (h == FRAME_START) begin
                    pad_phase  = PH_CMD;
                    r.tx_valid = 1'b1;
                    r.tx_byte  = cfg_on ? ID_CFG : (pad_mode == MODE_ANA) ? ID_ANA :
                                 (pad_mode == MODE_PRS) ? ID_PRS : ID_DIG;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // beat with the given opcode and host byte, the unused fields random
    function automatic t_in_item beat_of(t_opcode op, logic [7:0] h);
        logic [$bits(t_in_item)-1:0] raw;
        t_in_item                    b;
        raw         = $bits(t_in_item)'($urandom);
        b           = raw;
        b.opcode    = op;
        b.host_byte = h;
        return b;
    endfunction

    function automatic t_in_item load_of(int idx, logic [7:0] val);
        t_in_item b;
        b              = beat_of(OP_LOAD, 8'($urandom));
        b.report_index = 5'(idx);
        b.report_value = val;
        return b;
    endfunction

    function automatic t_out_item reply(bit v, logic [7:0] tx, bit d);
        t_out_item r;
        r.tx_valid   = v;
        r.tx_byte    = tx;
        r.frame_done = d;
        return r;
    endfunction

    function automatic void add_row(t_in_item b, bit fixed, t_out_item want);
        t_dir_row row;
        row.beat  = b;
        row.fixed = fixed;
        row.want  = want;
        dir_rows.push_back(row);
    endfunction

    // drive one input beat, wait for its acceptance, queue the expected reply
    task automatic send_beat(t_in_item b, bit fixed, t_out_item want);
        int        gap;
        t_out_item predicted;
        if ($urandom_range(0, 59) == 0) in_calm = !in_calm;
        gap = in_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (o_in_stall);
        predicted = answer_host(b);
        pending_replies.push_back(fixed ? want : predicted);
        if (b.opcode != OP_NOP) n_sent++;
    endtask

    // output side: random stall stretch after each beat, with calm spells
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if ($urandom_range(0, 99) == 0) out_calm = !out_calm;
            if (o_out_valid && !i_out_stall)
                hold_left = out_calm ? 0 : $urandom_range(0, 17);
            else if (hold_left != 0)
                hold_left--;
            i_out_stall <= (hold_left != 0);
        end
    end

    // reply checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_replies.size() == 0) begin
                $error("reply beat with nothing expected: %h", o_out_data);
                n_err++;
            end else begin
                want = pending_replies.pop_front();
                if (o_out_data.tx_valid !== want.tx_valid) begin
                    $error("tx_valid: expected %0d, got %0d", want.tx_valid, o_out_data.tx_valid);
                    n_err++;
                end
                if (o_out_data.tx_byte !== want.tx_byte) begin
                    $error("tx_byte: expected %h, got %h", want.tx_byte, o_out_data.tx_byte);
                    n_err++;
                end
                if (o_out_data.frame_done !== want.frame_done) begin
                    $error("frame_done: expected %0d, got %0d",
                           want.frame_done, o_out_data.frame_done);
                    n_err++;
                end
                n_checked++;
                if (o_out_data.frame_done) n_frames++;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        t_in_item   b;
        t_out_item  none;
        int         pick;
        logic [7:0] h;

        // model reset state
        foreach (rpt[k]) rpt[k] = 8'h00;
        foreach (motor[k]) motor[k] = 8'hFF;
        foreach (pres_cfg[k]) pres_cfg[k] = 8'h00;
        pad_mode  = MODE_DIG;
        cfg_on    = 1'b0;
        pad_phase = PH_IDLE;
        pad_cmd   = 8'h00;
        pad_pos   = '0;
        page      = 8'h00;
        none      = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: stray idle byte, no-op, loads, poll, refusals, config entry, abort
        add_row(beat_of(OP_HOST, 8'h00),      1, none);
        add_row(beat_of(OP_NOP, 8'h01),       1, none);
        add_row(load_of(31, 8'hFF),           1, none);
        add_row(load_of(0, 8'hFF),            1, none);
        add_row(load_of(1, 8'h00),            1, none);
        add_row(load_of(18, 8'hFF),           1, none);
        add_row(beat_of(OP_HOST, FRAME_START), 1, reply(1, ID_DIG, 0));
        add_row(beat_of(OP_HOST, CMD_READ_PAD), 0, none);
        add_row(beat_of(OP_HOST, 8'hFF),      0, none);
        add_row(beat_of(OP_HOST, 8'h00),      0, none);
        add_row(beat_of(OP_HOST, 8'h00),      1, reply(0, 8'h00, 1));
        add_row(beat_of(OP_HOST, FRAME_START), 1, reply(1, ID_DIG, 0));
        add_row(beat_of(OP_HOST, CMD_PRES_CFG), 1, reply(0, 8'h00, 1));
        add_row(beat_of(OP_HOST, FRAME_START), 1, reply(1, ID_DIG, 0));
        add_row(beat_of(OP_HOST, 8'hFF),      1, reply(0, 8'h00, 1));
        add_row(beat_of(OP_HOST, FRAME_START), 1, reply(1, ID_DIG, 0));
        add_row(beat_of(OP_HOST, CMD_CFG_MODE), 0, none);
        add_row(beat_of(OP_HOST, 8'h00),      0, none);
        add_row(beat_of(OP_HOST, 8'hFF),      0, none);
        add_row(beat_of(OP_HOST, 8'h00),      1, reply(0, 8'h00, 1));
        add_row(beat_of(OP_HOST, FRAME_START), 1, reply(1, ID_CFG, 0));
        add_row(beat_of(OP_HOST, CMD_MOTOR),  0, none);
        add_row(beat_of(OP_ABORT, 8'h00),     1, none);
        add_row(beat_of(OP_HOST, FRAME_START), 1, reply(1, ID_CFG, 0));
        add_row(beat_of(OP_HOST, CMD_PRES_INIT), 0, none);
        add_row(beat_of(OP_ABORT, 8'hFF),     1, none);
        foreach (dir_rows[k]) send_beat(dir_rows[k].beat, dir_rows[k].fixed, dir_rows[k].want);

        // random part: mostly whole frames with random content, some noise
        while (n_sent < RAND_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                case ($urandom_range(0, 3))
                    0: b = load_of($urandom_range(0, 31), 8'($urandom));
                    1: b = beat_of(OP_NOP, 8'($urandom));
                    2: b = beat_of(OP_ABORT, 8'($urandom));
                    default: b = beat_of(OP_HOST, 8'($urandom));
                endcase
                send_beat(b, 0, none);
            end else begin
                send_beat(beat_of(OP_HOST, FRAME_START), 0, none);
                case ($urandom_range(0, 19))
                    0, 1, 2, 3: h = CMD_READ_PAD;
                    4, 5, 6, 7: h = CMD_CFG_MODE;
                    8:          h = CMD_PRES_INIT;
                    9:          h = CMD_BTN_MASK;
                    10:         h = CMD_SET_MODE;
                    11:         h = CMD_PAD_INFO;
                    12:         h = CMD_ACT_INFO;
                    13:         h = CMD_COMB_INFO;
                    14:         h = CMD_MODE_INFO;
                    15:         h = CMD_MOTOR;
                    16:         h = CMD_PRES_CFG;
                    17:         h = 8'h48;
                    default:    h = 8'($urandom);
                endcase
                send_beat(beat_of(OP_HOST, h), 0, none);
                // payload until the frame closes, with the odd abort or load in between
                while (pad_phase == PH_PAY) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 2) begin
                        b = beat_of(OP_ABORT, 8'($urandom));
                    end else if (pick < 6) begin
                        b = load_of($urandom_range(0, 31), 8'($urandom));
                    end else begin
                        case ($urandom_range(0, 3))
                            0: h = 8'h00;
                            1: h = 8'h01;
                            default: h = 8'($urandom);
                        endcase
                        b = beat_of(OP_HOST, h);
                    end
                    send_beat(b, 0, none);
                end
            end
        end
        i_in_valid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Run covered %0d input beats and %0d checked replies, %0d frames closed.",
                 n_sent, n_checked, n_frames);
        if (n_err == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: gamepad_serial_responder.f
src/gsr_pkg.sv
src/gamepad_serial_responder.sv
tb/sv/tb_gamepad_serial_responder.sv
